>>> hdl/mid_pkg.sv
// Shared types and constants for the minimum image distance core.
// No dependencies; imported by the lane and top-level modules.
`default_nettype none

package mid_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int PERIODIC_BITS  = 3;
    localparam int CFG_INDEX_BITS = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_BOX_X    = 2'd0,
        REG_BOX_Y    = 2'd1,
        REG_BOX_Z    = 2'd2,
        REG_PERIODIC = 2'd3
    } cfg_reg_t;

    // per-stage advance strobes of one axis lane
    typedef struct packed {
        logic diff;
        logic wrap;
        logic square;
    } lane_en_t;

endpackage

`default_nettype wire

>>> hdl/mid_axis_lane.sv
// One axis lane: absolute difference, minimum image wrap, square.
// Three register stages; depends on mid_pkg.
`default_nettype none

module mid_axis_lane #(
    parameter int COORD_BITS = mid_pkg::COORD_BITS_DEF
) (
    input  wire                      clk,
    input  wire mid_pkg::lane_en_t   en,
    input  wire [COORD_BITS-1:0]     first,
    input  wire [COORD_BITS-1:0]     second,
    input  wire [COORD_BITS-1:0]     box_len,
    input  wire                      periodic,
    output logic [2*COORD_BITS-1:0]  square
);
    import mid_pkg::*;

    localparam int SQ_BITS = 2 * COORD_BITS;

    logic [COORD_BITS-1:0] diff_reg;
    logic [COORD_BITS-1:0] diff_next;
    logic [COORD_BITS-1:0] len_reg;
    logic [COORD_BITS-1:0] len_next;
    logic [COORD_BITS-1:0] wrap;
    logic [SQ_BITS-1:0]    len_ext;
    logic [SQ_BITS-1:0]    square_reg;
    logic [SQ_BITS-1:0]    square_next;

    always_comb
    begin
        diff_next = (second >= first) ? (second - first) : (first - second);
        wrap      = (box_len >= diff_reg) ? (box_len - diff_reg) : (diff_reg - box_len);
        len_next  = (periodic && (wrap < diff_reg)) ? wrap : diff_reg;
        len_ext     = {{COORD_BITS{1'b0}}, len_reg};
        square_next = len_ext * len_ext;
    end

    always_ff @(posedge clk)
    begin
        if (en.diff)
        begin
            diff_reg <= diff_next;
        end
        if (en.wrap)
        begin
            len_reg <= len_next;
        end
        if (en.square)
        begin
            square_reg <= square_next;
        end
    end

    assign square = square_reg;

endmodule

`default_nettype wire

>>> hdl/mid_merge.sv
// Merge stage: adds the three lane squares into one registered sum.
// Depends on mid_pkg for the default coordinate width.
`default_nettype none

module mid_merge #(
    parameter int COORD_BITS = mid_pkg::COORD_BITS_DEF
) (
    input  wire                        clk,
    input  wire                        en,
    input  wire [2*COORD_BITS-1:0]     square_x,
    input  wire [2*COORD_BITS-1:0]     square_y,
    input  wire [2*COORD_BITS-1:0]     square_z,
    output logic [2*COORD_BITS+3:0]    sum
);
    localparam int SUM_BITS = 2 * COORD_BITS + 4;

    logic [SUM_BITS-1:0] sum_reg;
    logic [SUM_BITS-1:0] sum_next;

    always_comb
    begin
        sum_next = {4'b0, square_x} + {4'b0, square_y} + {4'b0, square_z};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

>>> hdl/mid_root_step.sv
// One digit step of the restoring integer square root, registered.
// Standalone; chained by the top level, one instance per result bit.
`default_nettype none

module mid_root_step #(
    parameter int WIDTH = 52,
    parameter int SHIFT = 50
) (
    input  wire              clk,
    input  wire              en,
    input  wire [WIDTH-1:0]  rem_in,
    input  wire [WIDTH-1:0]  res_in,
    output logic [WIDTH-1:0] rem_out,
    output logic [WIDTH-1:0] res_out
);
    localparam logic [WIDTH-1:0] BIT = {{(WIDTH-1){1'b0}}, 1'b1} << SHIFT;

    logic [WIDTH-1:0] trial;
    logic             take;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] res_reg;
    logic [WIDTH-1:0] res_next;

    always_comb
    begin
        trial    = res_in + BIT;
        take     = (rem_in >= trial);
        rem_next = take ? (rem_in - trial) : rem_in;
        res_next = take ? ((res_in >> 1) + BIT) : (res_in >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            res_reg <= res_next;
        end
    end

    assign rem_out = rem_reg;
    assign res_out = res_reg;

endmodule

`default_nettype wire

>>> hdl/minimum_image_distance_core.sv
// Minimum image distance core: top level with config registers and pipeline control.
// Depends on mid_pkg, mid_axis_lane, mid_merge and mid_root_step.
//
// Takes two 3D points in unsigned fixed point and returns the floor of their
// Euclidean distance, each periodic axis using min(|b-a|, |box-|b-a||). One
// request is taken every cycle while in_stall is low. A request passes the
// per-axis lane registers, one register to add the squares, and the square
// root steps, one per result bit, in that order. Every stage holds its
// request only while the stage after it is full and blocked, so empty stages
// keep filling while a finished result waits on out_stall. Box lengths and
// the periodic mask are read live and should be written only while idle.
`default_nettype none

module minimum_image_distance_core #(
    parameter int COORD_BITS = mid_pkg::COORD_BITS_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_write_en,
    input  wire [mid_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire [COORD_BITS-1:0]              cfg_data,
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire [COORD_BITS-1:0]              first_x,
    input  wire [COORD_BITS-1:0]              first_y,
    input  wire [COORD_BITS-1:0]              first_z,
    input  wire [COORD_BITS-1:0]              second_x,
    input  wire [COORD_BITS-1:0]              second_y,
    input  wire [COORD_BITS-1:0]              second_z,
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic [COORD_BITS:0]               separation
);
    import mid_pkg::*;

    localparam int ROOT_STEPS = COORD_BITS + 2;
    localparam int SUM_BITS   = 2 * ROOT_STEPS;
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int STAGES     = 4 + ROOT_STEPS;

    logic [COORD_BITS-1:0]    box_x_reg;
    logic [COORD_BITS-1:0]    box_y_reg;
    logic [COORD_BITS-1:0]    box_z_reg;
    logic [PERIODIC_BITS-1:0] periodic_reg;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] en;
    lane_en_t          lane_en;

    logic [SQ_BITS-1:0]  square_x;
    logic [SQ_BITS-1:0]  square_y;
    logic [SQ_BITS-1:0]  square_z;
    logic [SUM_BITS-1:0] sum;
    logic [SUM_BITS-1:0] rem_w [ROOT_STEPS+1];
    logic [SUM_BITS-1:0] res_w [ROOT_STEPS+1];

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg    <= '1;
            box_y_reg    <= '1;
            box_z_reg    <= '1;
            periodic_reg <= '1;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BOX_X:    box_x_reg    <= cfg_data;
                REG_BOX_Y:    box_y_reg    <= cfg_data;
                REG_BOX_Z:    box_z_reg    <= cfg_data;
                REG_PERIODIC: periodic_reg <= cfg_data[PERIODIC_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // stage i advances unless it and every stage after it is full and the
    // output is blocked
    always_comb
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            en[i] = !out_stall ||
                    !(&(valid_reg | (({{(STAGES-1){1'b0}}, 1'b1} << i)
                                     - {{(STAGES-1){1'b0}}, 1'b1})));
        end
        valid_next = {valid_reg[STAGES-2:0], in_valid};
        for (int i = 0; i < STAGES; i++)
        begin
            if (!en[i])
            begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign lane_en.diff   = en[0];
    assign lane_en.wrap   = en[1];
    assign lane_en.square = en[2];

    mid_axis_lane #(.COORD_BITS(COORD_BITS)) u_lane_x (
        .clk      (clk),
        .en       (lane_en),
        .first    (first_x),
        .second   (second_x),
        .box_len  (box_x_reg),
        .periodic (periodic_reg[0]),
        .square   (square_x)
    );

    mid_axis_lane #(.COORD_BITS(COORD_BITS)) u_lane_y (
        .clk      (clk),
        .en       (lane_en),
        .first    (first_y),
        .second   (second_y),
        .box_len  (box_y_reg),
        .periodic (periodic_reg[1]),
        .square   (square_y)
    );

    mid_axis_lane #(.COORD_BITS(COORD_BITS)) u_lane_z (
        .clk      (clk),
        .en       (lane_en),
        .first    (first_z),
        .second   (second_z),
        .box_len  (box_z_reg),
        .periodic (periodic_reg[2]),
        .square   (square_z)
    );

    mid_merge #(.COORD_BITS(COORD_BITS)) u_merge (
        .clk      (clk),
        .en       (en[3]),
        .square_x (square_x),
        .square_y (square_y),
        .square_z (square_z),
        .sum      (sum)
    );

    assign rem_w[0] = sum;
    assign res_w[0] = '0;

    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_root
        mid_root_step #(
            .WIDTH (SUM_BITS),
            .SHIFT (2 * (ROOT_STEPS - 1 - k))
        ) u_step (
            .clk     (clk),
            .en      (en[4+k]),
            .rem_in  (rem_w[k]),
            .res_in  (res_w[k]),
            .rem_out (rem_w[k+1]),
            .res_out (res_w[k+1])
        );
    end

    assign in_stall   = !en[0];
    assign out_valid  = valid_reg[STAGES-1];
    assign separation = res_w[ROOT_STEPS][COORD_BITS:0];

endmodule

`default_nettype wire
